// File: rtl/triangle_circumcircle_assert.svh
// Assertion macros for the circumcircle block; clk and rst_n are taken from the enclosing module.
`ifndef TRIANGLE_CIRCUMCIRCLE_ASSERT_SVH
`define TRIANGLE_CIRCUMCIRCLE_ASSERT_SVH

// Same-cycle implication.
`define TCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcc_pkg.sv
package tcc_pkg;

  localparam int CEN_W = 32;
  localparam int RAD_W = 48;
  localparam int RQ_W  = 2 * RAD_W;
  localparam int MCH_W = 16;

  localparam logic [CEN_W-1:0] CEN_LIM_POS = {1'b0, {(CEN_W-1){1'b1}}};
  localparam logic [CEN_W-1:0] CEN_LIM_NEG = {1'b1, {(CEN_W-1){1'b0}}};

endpackage

// File: rtl/triangle_circumcircle.sv
// Circumscribed circle of three integer points. One beat is taken per cycle while in_stall
// is low, and each beat gives one result beat, in order. The pipeline depth is set by the
// 96-step radius divider and the 48-step square root that follows it, one step per
// pipeline stage; the centre divider runs alongside. Collinear points give valid_res low
// and all other fields zero. Stall on the result side holds the whole pipeline only once
// its last stage is occupied.
`include "triangle_circumcircle_assert.svh"

module triangle_circumcircle import tcc_pkg::*; #(
  parameter int COORD_BITS       = 16,
  parameter int RADIUS_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  input  logic signed [COORD_BITS-1:0] in_third_x,
  input  logic signed [COORD_BITS-1:0] in_third_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_valid_res,
  output logic signed [CEN_W-1:0]      out_center_x,
  output logic signed [CEN_W-1:0]      out_center_y,
  output logic        [RAD_W-1:0]      out_radius,
  output logic                         out_saturated
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int TW   = 2 * CB;
  localparam int QW   = 2 * CB;
  localparam int PW   = 2 * DW;
  localparam int TMW  = TW + 1 + DW;
  localparam int DETW = PW + 1;
  localparam int SW   = 2 * CB + 1;
  localparam int NW   = TMW + 2;
  localparam int ADW  = 2 * CB + 2;
  localparam int MCH  = (ADW + MCH_W - 1) / MCH_W;
  localparam int MPW  = MCH * MCH_W;
  localparam int ABW  = 2 * SW;
  localparam int DENW = 2 * ADW;
  localparam int NUMW = 3 * SW;
  localparam int RNW  = NUMW + 2 * RADIUS_FRAC_BITS;
  localparam int RCW  = ((RNW > DENW + RQ_W) ? RNW : DENW + RQ_W) + 1;
  localparam int CRW  = ((NW > ADW + CEN_W) ? NW : ADW + CEN_W) + 1;
  localparam int SCW  = RQ_W + 2;

  // stage map
  localparam int S_DIF = 1;
  localparam int S_PRD = 2;
  localparam int S_SUM = 3;
  localparam int S_NUM = 4;
  localparam int CD0   = 5;
  localparam int M1_0  = 5;
  localparam int M2_0  = M1_0 + MCH;
  localparam int RD0   = M2_0 + MCH;
  localparam int SQ0   = RD0 + 1 + RQ_W;
  localparam int NST   = SQ0 + RAD_W;
  localparam int LAST  = NST - 1;

  typedef struct packed {
    logic signed [CB-1:0]   x1, y1, x2, y2, x3, y3;
    logic signed [DW-1:0]   dx21, dy31, dx31, dy21, dy23, dy12, dx32, dx13;
    logic        [TW-1:0]   xs1, ys1, xs2, ys2, xs3, ys3;
    logic signed [PW-1:0]   pa, pb;
    logic        [QW-1:0]   qa1, qa2, qb1, qb2, qc1, qc2;
    logic        [TW-1:0]   t1, t2, t3;
    logic signed [TMW-1:0]  tx1, tx2, tx3, ty1, ty2, ty3;
    logic signed [DETW-1:0] det;
    logic        [SW-1:0]   sa, sb, sc;
    logic signed [NW-1:0]   nx, ny;
    logic                   dz, dn;
    logic        [ADW-1:0]  ad2;
    logic        [ABW-1:0]  ab;
    logic        [DENW-1:0] den;
    logic        [NUMW-1:0] num;
    logic        [NW-1:0]   cxm, cym;
    logic                   cxn, cyn, cxs, cys;
    logic        [CEN_W-1:0] cxq, cyq;
    logic        [RNW-1:0]  rrem;
    logic                   rsat;
    logic        [RQ_W-1:0] rq;
    logic        [RQ_W-1:0] sqrem;
    logic        [RAD_W-1:0] root;
  } pl_t;

  pl_t            st_r [NST];
  logic [NST-1:0] vld_r;
  logic           adv;
  logic           out_ld;

  logic                    out_valid_r;
  logic                    res_r, res_nxt;
  logic [CEN_W-1:0]        cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RAD_W-1:0]        rad_r, rad_nxt;
  logic                    sat_r, sat_nxt;

  assign out_ld   = !out_valid_r || !out_stall;
  assign adv      = out_ld || !vld_r[LAST];
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int JA = (k >= M1_0 && k < M1_0 + MCH) ? k - M1_0 : 0;
    localparam int JB = (k >= M2_0 && k < M2_0 + MCH) ? k - M2_0 : 0;
    localparam int BC = (k >= CD0 + 2 && k < CD0 + 2 + CEN_W) ? CEN_W - 1 - (k - CD0 - 2) : 0;
    localparam int BR = (k >= RD0 + 1 && k < RD0 + 1 + RQ_W) ? RQ_W - 1 - (k - RD0 - 1) : 0;
    localparam int BS = (k >= SQ0 && k < SQ0 + RAD_W) ? RAD_W - 1 - (k - SQ0) : 0;

    pl_t st_nxt;

    if (k == 0) begin : g_in
      always_comb begin
        st_nxt    = '0;
        st_nxt.x1 = in_first_x;
        st_nxt.y1 = in_first_y;
        st_nxt.x2 = in_second_x;
        st_nxt.y2 = in_second_y;
        st_nxt.x3 = in_third_x;
        st_nxt.y3 = in_third_y;
      end
    end else begin : g_wk
      always_comb begin
        pl_t                   p;
        logic [DETW-1:0]       adet;
        logic [MCH_W-1:0]      ch_a, ch_d, ch_c;
        logic [SW+MCH_W-1:0]   mab;
        logic [ADW+MCH_W-1:0]  mdd;
        logic [ABW+MCH_W-1:0]  mn;
        logic [RNW-1:0]        rn;
        logic [CRW-1:0]        dvc;
        logic [RCW-1:0]        dvr;
        logic [RQ_W-1:0]       src;
        logic [SCW-1:0]        trial;
        logic [CEN_W-1:0]      limx, limy;
        p      = st_r[k-1];
        st_nxt = p;
        adet   = '0;
        ch_a   = '0;
        ch_d   = '0;
        ch_c   = '0;
        mab    = '0;
        mdd    = '0;
        mn     = '0;
        rn     = '0;
        dvc    = '0;
        dvr    = '0;
        src    = '0;
        trial  = '0;
        limx   = '0;
        limy   = '0;

        if (k == S_DIF) begin
          st_nxt.dx21 = DW'(p.x2) - DW'(p.x1);
          st_nxt.dy31 = DW'(p.y3) - DW'(p.y1);
          st_nxt.dx31 = DW'(p.x3) - DW'(p.x1);
          st_nxt.dy21 = DW'(p.y2) - DW'(p.y1);
          st_nxt.dy23 = DW'(p.y2) - DW'(p.y3);
          st_nxt.dy12 = DW'(p.y1) - DW'(p.y2);
          st_nxt.dx32 = DW'(p.x3) - DW'(p.x2);
          st_nxt.dx13 = DW'(p.x1) - DW'(p.x3);
          st_nxt.xs1  = TW'(TW'(p.x1) * TW'(p.x1));
          st_nxt.ys1  = TW'(TW'(p.y1) * TW'(p.y1));
          st_nxt.xs2  = TW'(TW'(p.x2) * TW'(p.x2));
          st_nxt.ys2  = TW'(TW'(p.y2) * TW'(p.y2));
          st_nxt.xs3  = TW'(TW'(p.x3) * TW'(p.x3));
          st_nxt.ys3  = TW'(TW'(p.y3) * TW'(p.y3));
        end

        if (k == S_PRD) begin
          st_nxt.pa  = PW'(p.dx21) * PW'(p.dy31);
          st_nxt.pb  = PW'(p.dx31) * PW'(p.dy21);
          st_nxt.qa1 = QW'(PW'(p.dx21) * PW'(p.dx21));
          st_nxt.qa2 = QW'(PW'(p.dy12) * PW'(p.dy12));
          st_nxt.qb1 = QW'(PW'(p.dx13) * PW'(p.dx13));
          st_nxt.qb2 = QW'(PW'(p.dy31) * PW'(p.dy31));
          st_nxt.qc1 = QW'(PW'(p.dx32) * PW'(p.dx32));
          st_nxt.qc2 = QW'(PW'(p.dy23) * PW'(p.dy23));
          st_nxt.t1  = p.xs1 + p.ys1;
          st_nxt.t2  = p.xs2 + p.ys2;
          st_nxt.t3  = p.xs3 + p.ys3;
        end

        if (k == S_SUM) begin
          st_nxt.det = DETW'(p.pa) - DETW'(p.pb);
          st_nxt.sa  = SW'(p.qa1) + SW'(p.qa2);
          st_nxt.sb  = SW'(p.qb1) + SW'(p.qb2);
          st_nxt.sc  = SW'(p.qc1) + SW'(p.qc2);
          st_nxt.tx1 = TMW'($signed({1'b0, p.t1})) * TMW'(p.dy23);
          st_nxt.tx2 = TMW'($signed({1'b0, p.t2})) * TMW'(p.dy31);
          st_nxt.tx3 = TMW'($signed({1'b0, p.t3})) * TMW'(p.dy12);
          st_nxt.ty1 = TMW'($signed({1'b0, p.t1})) * TMW'(p.dx32);
          st_nxt.ty2 = TMW'($signed({1'b0, p.t2})) * TMW'(p.dx13);
          st_nxt.ty3 = TMW'($signed({1'b0, p.t3})) * TMW'(p.dx21);
        end

        if (k == S_NUM) begin
          st_nxt.nx  = NW'(p.tx1) + NW'(p.tx2) + NW'(p.tx3);
          st_nxt.ny  = NW'(p.ty1) + NW'(p.ty2) + NW'(p.ty3);
          st_nxt.dz  = (p.det == '0);
          st_nxt.dn  = p.det[DETW-1];
          adet       = p.det[DETW-1] ? DETW'(-p.det) : DETW'(p.det);
          st_nxt.ad2 = ADW'(adet) << 1;
        end

        // centre: magnitude, range check, 32 restoring steps, clamp
        if (k == CD0) begin
          st_nxt.cxm = p.nx[NW-1] ? NW'(-p.nx) : NW'(p.nx);
          st_nxt.cym = p.ny[NW-1] ? NW'(-p.ny) : NW'(p.ny);
          st_nxt.cxn = p.nx[NW-1] ^ p.dn;
          st_nxt.cyn = p.ny[NW-1] ^ p.dn;
        end

        if (k == CD0 + 1) begin
          st_nxt.cxs = CRW'(p.cxm) >= (CRW'(p.ad2) << CEN_W);
          st_nxt.cys = CRW'(p.cym) >= (CRW'(p.ad2) << CEN_W);
        end

        if (k >= CD0 + 2 && k < CD0 + 2 + CEN_W) begin
          dvc = CRW'(p.ad2) << BC;
          if (CRW'(p.cxm) >= dvc) begin
            st_nxt.cxm     = NW'(CRW'(p.cxm) - dvc);
            st_nxt.cxq[BC] = 1'b1;
          end
          if (CRW'(p.cym) >= dvc) begin
            st_nxt.cym     = NW'(CRW'(p.cym) - dvc);
            st_nxt.cyq[BC] = 1'b1;
          end
        end

        if (k == CD0 + 2 + CEN_W) begin
          limx = p.cxn ? CEN_LIM_NEG : CEN_LIM_POS;
          limy = p.cyn ? CEN_LIM_NEG : CEN_LIM_POS;
          if (p.cxs || p.cxq > limx) begin
            st_nxt.cxs = 1'b1;
            st_nxt.cxq = limx;
          end
          if (p.cys || p.cyq > limy) begin
            st_nxt.cys = 1'b1;
            st_nxt.cyq = limy;
          end
        end

        // sa*sb and (2|D|)^2, one 16-bit slice per stage
        if (k >= M1_0 && k < M1_0 + MCH) begin
          ch_a      = MCH_W'(MPW'(p.sb) >> (MCH_W * JA));
          ch_d      = MCH_W'(MPW'(p.ad2) >> (MCH_W * JA));
          mab       = {{MCH_W{1'b0}}, p.sa} * {{SW{1'b0}}, ch_a};
          mdd       = {{MCH_W{1'b0}}, p.ad2} * {{ADW{1'b0}}, ch_d};
          st_nxt.ab  = p.ab + (ABW'(mab) << (MCH_W * JA));
          st_nxt.den = p.den + (DENW'(mdd) << (MCH_W * JA));
        end

        if (k >= M2_0 && k < M2_0 + MCH) begin
          ch_c       = MCH_W'(MPW'(p.sc) >> (MCH_W * JB));
          mn         = {{MCH_W{1'b0}}, p.ab} * {{ABW{1'b0}}, ch_c};
          st_nxt.num = p.num + (NUMW'(mn) << (MCH_W * JB));
        end

        // radius squared: num * 2^(2F) / den, 96 quotient bits
        if (k == RD0) begin
          rn          = RNW'(p.num) << (2 * RADIUS_FRAC_BITS);
          st_nxt.rrem = rn;
          st_nxt.rsat = RCW'(rn) >= (RCW'(p.den) << RQ_W);
        end

        if (k >= RD0 + 1 && k < RD0 + 1 + RQ_W) begin
          dvr = RCW'(p.den) << BR;
          if (RCW'(p.rrem) >= dvr) begin
            st_nxt.rrem   = RNW'(RCW'(p.rrem) - dvr);
            st_nxt.rq[BR] = 1'b1;
          end
        end

        // integer square root, one result bit per stage
        if (k >= SQ0 && k < SQ0 + RAD_W) begin
          src   = (k == SQ0) ? p.rq : p.sqrem;
          trial = (SCW'(p.root) << (BS + 1)) + (SCW'(1) << (2 * BS));
          if (SCW'(src) >= trial) begin
            st_nxt.sqrem    = RQ_W'(SCW'(src) - trial);
            st_nxt.root[BS] = 1'b1;
          end else begin
            st_nxt.sqrem = src;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt;
      end
    end
  end

  always_comb begin
    pl_t lp;
    lp      = st_r[LAST];
    res_nxt = !lp.dz;
    cx_nxt  = lp.dz ? '0 : (lp.cxn ? CEN_W'(CEN_W'(0) - lp.cxq) : lp.cxq);
    cy_nxt  = lp.dz ? '0 : (lp.cyn ? CEN_W'(CEN_W'(0) - lp.cyq) : lp.cyq);
    rad_nxt = lp.dz ? '0 : (lp.rsat ? '1 : lp.root);
    sat_nxt = !lp.dz && (lp.cxs || lp.cys || lp.rsat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      res_r <= res_nxt;
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      rad_r <= rad_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_r;
  assign out_center_x  = cx_r;
  assign out_center_y  = cy_r;
  assign out_radius    = rad_r;
  assign out_saturated = sat_r;

  `TCC_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid_r && out_stall && vld_r[LAST], "input stalled without a blocked last stage")
  `TCC_ASSERT_NXT(a_hold_when_blocked, !adv, $stable(vld_r), "pipeline valid bits moved while blocked")
  `TCC_ASSERT_NXT(a_last_lands, adv && vld_r[LAST], out_valid_r, "beat from last stage lost")
  `TCC_ASSERT_NOW(a_collinear_zero, out_valid_r && !res_r, cx_r == '0 && cy_r == '0 && rad_r == '0 && !sat_r, "collinear result carries non-zero fields")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb import tcc_pkg::*; ();

  typedef struct packed {
    logic             valid_res;
    logic [CEN_W-1:0] center_x;
    logic [CEN_W-1:0] center_y;
    logic [RAD_W-1:0] radius;
    logic             saturated;
  } circle_t;

  class circle_scoreboard;
    circle_t circles_due[$];
    int      mismatches;

    function automatic logic [CEN_W-1:0] centre_coord(longint num, longint det,
                                                      ref bit sat);
      longint mag, ad, q, lim;
      bit     neg;
      mag = num < 0 ? -num : num;
      ad  = det < 0 ? -det : det;
      q   = mag / (2 * ad);
      neg = (num < 0) ^ (det < 0);
      lim = neg ? 64'sd2147483648 : 64'sd2147483647;
      if (q > lim) begin
        q   = lim;
        sat = 1'b1;
      end
      return CEN_W'(neg ? -q : q);
    endfunction

    function automatic circle_t circumcircle(longint x1, longint y1, longint x2,
                                             longint y2, longint x3, longint y3);
      circle_t     c;
      longint      det, t1, t2, t3, nx, ny;
      logic [255:0] sa, sb, sc, num, den, q, cand, rad;
      bit          sat;
      c   = '{default: '0};
      sat = 1'b0;
      det = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
      if (det == 0) return c;
      t1 = x1 * x1 + y1 * y1;
      t2 = x2 * x2 + y2 * y2;
      t3 = x3 * x3 + y3 * y3;
      nx = t1 * (y2 - y3) + t2 * (y3 - y1) + t3 * (y1 - y2);
      ny = t1 * (x3 - x2) + t2 * (x1 - x3) + t3 * (x2 - x1);
      c.valid_res = 1'b1;
      c.center_x  = centre_coord(nx, det, sat);
      c.center_y  = centre_coord(ny, det, sat);
      sa  = 256'((x1 - x2) * (x1 - x2) + (y1 - y2) * (y1 - y2));
      sb  = 256'((x1 - x3) * (x1 - x3) + (y1 - y3) * (y1 - y3));
      sc  = 256'((x2 - x3) * (x2 - x3) + (y2 - y3) * (y2 - y3));
      num = (sa * sb * sc) << 16;
      den = 256'(2 * (det < 0 ? -det : det));
      den = den * den;
      q   = num / den;
      if ((q >> 96) != 0) begin
        c.radius = '1;
        sat      = 1'b1;
      end else begin
        rad = '0;
        for (int b = RAD_W - 1; b >= 0; b--) begin
          cand = rad | (256'd1 << b);
          if (cand * cand <= q) rad = cand;
        end
        c.radius = rad[RAD_W-1:0];
      end
      c.saturated = sat;
      return c;
    endfunction

    function void note_points(logic signed [15:0] x1, y1, x2, y2, x3, y3);
      circles_due.push_back(circumcircle(x1, y1, x2, y2, x3, y3));
    endfunction

    function int pending();
      return circles_due.size();
    endfunction

    function void check_circle(circle_t got);
      circle_t want;
      if (circles_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat");
        return;
      end
      want = circles_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp v=%0d cx=%0d cy=%0d r=%h s=%0d ",
                    "got v=%0d cx=%0d cy=%0d r=%h s=%0d"},
                   want.valid_res, $signed(want.center_x), $signed(want.center_y),
                   want.radius, want.saturated, got.valid_res, $signed(got.center_x),
                   $signed(got.center_y), got.radius, got.saturated);
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  logic signed [15:0] in_first_x, in_first_y, in_second_x, in_second_y, in_third_x, in_third_y;
  logic out_valid_res, out_saturated;
  logic signed [CEN_W-1:0] out_center_x, out_center_y;
  logic [RAD_W-1:0] out_radius;

  circle_scoreboard sb = new();
  int  beats_taken;
  bit  quiet;
  bit  held;

  triangle_circumcircle dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("** triangle_circumcircle: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_points(in_first_x, in_first_y, in_second_x, in_second_y, in_third_x, in_third_y);
      beats_taken++;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_circle('{out_valid_res, out_center_x, out_center_y, out_radius, out_saturated});
  end

  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      if (!held && beats_taken >= 300) begin
        out_stall <= 1;
        repeat (500) @(posedge clk);
        out_stall <= 0;
        held = 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_triangle(int x1, y1, x2, y2, x3, y3);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid    <= 1;
    in_first_x  <= 16'(x1);
    in_first_y  <= 16'(y1);
    in_second_x <= 16'(x2);
    in_second_y <= 16'(y2);
    in_third_x  <= 16'(x3);
    in_third_y  <= 16'(y3);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int n);
    int x, y, dx, dy;
    for (int i = 0; i < n; i++) begin
      if (i == n - 250) quiet = 1;
      case ($urandom_range(0, 3))
        0: send_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        1: send_triangle($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                         $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                         $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
        2: begin
          x  = $urandom_range(0, 2000) - 1000;
          y  = $urandom_range(0, 2000) - 1000;
          dx = $urandom_range(0, 200) - 100;
          dy = $urandom_range(0, 200) - 100;
          send_triangle(x, y, x + dx, y + dy, x + 2 * dx + $urandom_range(0, 2) - 1,
                        y + 2 * dy);
        end
        default: send_triangle($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100,
                               $urandom, $urandom, $urandom_range(0, 200) - 100,
                               $urandom_range(0, 200) - 100);
      endcase
      if (i == 900) begin
        in_valid <= 0;
        do @(posedge clk); while (sb.pending() != 0);
      end
    end
  endtask

  initial begin
    int guard;
    rst_n       = 0;
    in_valid    = 0;
    in_first_x  = '0;
    in_first_y  = '0;
    in_second_x = '0;
    in_second_y = '0;
    in_third_x  = '0;
    in_third_y  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_triangle(0, 0, 0, 0, 0, 0);
    send_triangle(1, 2, 3, 4, 5, 6);
    send_triangle(-32768, -32768, 32767, 32767, 0, 0);
    send_triangle(0, 0, 1, 0, 0, 1);
    send_triangle(0, 0, 2, 0, 0, 2);
    send_triangle(-1, 0, 1, 0, 0, 1);
    send_triangle(0, 0, 1, 0, 0, -1);
    send_triangle(-32768, -32768, 32767, 32767, 32767, 32766);
    send_triangle(-32768, 32767, 32767, -32768, 32767, -32767);
    send_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
    send_triangle(32767, 32767, -32768, -32768, -32767, -32768);
    send_triangle(-32768, 0, 32767, 1, 0, 0);
    send_triangle(-32768, -32768, -32768, 32767, 32767, -32768);
    send_triangle(32767, 32767, 32767, -32768, -32768, 32767);
    send_triangle(5, 5, 5, 5, 6, 7);
    send_triangle(-32768, -32768, -32767, -32767, 32767, 32767);
    send_triangle(0, 32767, 0, -32768, 1, 0);
    send_triangle(3, -4, -3, 4, 4, 3);
    send_triangle(-2, -2, -1, -1, 100, 101);
    send_triangle(32767, 0, -32768, 0, 0, -32768);
    send_random(1630);
    in_valid <= 0;
    guard = 0;
    while (sb.pending() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** triangle_circumcircle: PASSED **");
    end else begin
      $display("** triangle_circumcircle: FAILED **");
    end
    $finish;
  end

endmodule
